// ----- hw/rtl/lgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types, sizes, codes and helpers for the life generation step block.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W    = 4;

  localparam logic [CNT_W-1:0] BIRTH_COUNT   = CNT_W'(3);
  localparam logic [CNT_W-1:0] SURVIVE_COUNT = CNT_W'(2);

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CLIP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(2);

  typedef logic [MAX_COLS-1:0] row_bits_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             cell_value;
  } req_t;

  typedef struct packed {
    logic alive;
    logic status;
  } rsp_t;

  typedef struct packed {
    row_bits_t up;
    row_bits_t cur;
    row_bits_t dn;
  } window_t;

  typedef struct packed {
    logic             clip;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] last_col;
  } col_ctl_t;

  function automatic logic [ROW_W-1:0] last_row_of(logic [CFG_W-1:0] n);
    if (n == '0) begin
      return '0;
    end else if (n > CFG_W'(MAX_ROWS)) begin
      return ROW_W'(MAX_ROWS - 1);
    end else begin
      return ROW_W'(n - 1'b1);
    end
  endfunction

  function automatic logic [COL_W-1:0] last_col_of(logic [CFG_W-1:0] n);
    if (n == '0) begin
      return '0;
    end else if (n > CFG_W'(MAX_COLS)) begin
      return COL_W'(MAX_COLS - 1);
    end else begin
      return COL_W'(n - 1'b1);
    end
  endfunction

endpackage

// ----- hw/rtl/life_generation_step.sv -----
// ----------------------------------------------------------------------------
// life_generation_step
// Cell grid with write, read and one-generation advance (B3/S23, clip or wrap).
//
//   channel  | direction | handshake           | payload
//   req      | in        | req_valid/req_stall | action, row, col, cell_value
//   rsp      | out       | rsp_valid/rsp_stall | alive, status
//   cfg      | in        | cfg_write           | cfg_index, cfg_data
//
// write/read: ST_CELL, then ST_RESP; out of range or unused skip ST_CELL.
// advance: per row, window loads (ST_GUP to ST_GLOAD), then the single rule
// unit evaluates one cell per cycle, then ST_GWR; a copy-back pass follows.
// reset: synchronous, clears all row valid bits, so the grid reads dead.
// req_stall is high while an item is in work; a stalled response holds in rsp.
// ----------------------------------------------------------------------------
module life_generation_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  lgs_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output lgs_pkg::rsp_t                 rsp,
  input  logic                          cfg_write,
  input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lgs_pkg::CFG_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CELL,
    ST_GUP,
    ST_GCUR,
    ST_GDN,
    ST_GLOAD,
    ST_GCOL,
    ST_GWR,
    ST_CRD,
    ST_CWR,
    ST_RESP
  } state_t;

  state_t                    state;
  lgs_pkg::req_t             item;
  logic                      clip_edges;
  logic [lgs_pkg::CFG_W-1:0] rows_in_use;
  logic [lgs_pkg::CFG_W-1:0] cols_in_use;
  logic [lgs_pkg::ROW_W-1:0] last_row;
  logic [lgs_pkg::COL_W-1:0] last_col;
  logic [lgs_pkg::ROW_W-1:0] row_cnt;
  logic [lgs_pkg::ROW_W-1:0] gen_last_row;
  logic [lgs_pkg::COL_W-1:0] col_cnt;
  logic [lgs_pkg::COL_W-1:0] gen_last_col;
  logic [lgs_pkg::ROW_W-1:0] up_addr;
  logic [lgs_pkg::ROW_W-1:0] dn_addr;
  logic [lgs_pkg::ROW_W-1:0] rd_addr;
  logic [lgs_pkg::MAX_ROWS-1:0] row_valid;
  logic                      rd_ok;
  lgs_pkg::row_bits_t        rd_data;
  lgs_pkg::row_bits_t        row_data;
  lgs_pkg::row_bits_t        nx_rd_data;
  lgs_pkg::row_bits_t        up_row;
  lgs_pkg::row_bits_t        cur_row;
  lgs_pkg::row_bits_t        dn_row;
  lgs_pkg::row_bits_t        next_row;
  logic                      res_alive;
  logic                      res_status;
  logic                      cell_wr_en;
  logic [lgs_pkg::ROW_W-1:0] cell_wr_addr;
  lgs_pkg::row_bits_t        cell_wr_data;
  logic                      cell_next;
  lgs_pkg::window_t          win;
  lgs_pkg::col_ctl_t         ctl;

  lgs_pkg::row_bits_t        cell_mem [lgs_pkg::MAX_ROWS];
  lgs_pkg::row_bits_t        next_mem [lgs_pkg::MAX_ROWS];

  assign req_stall = (state != ST_IDLE);
  assign last_row  = lgs_pkg::last_row_of(rows_in_use);
  assign last_col  = lgs_pkg::last_col_of(cols_in_use);
  assign row_data  = rd_ok ? rd_data : '0;

  assign win = '{up: up_row, cur: cur_row, dn: dn_row};
  assign ctl = '{clip: clip_edges, col: col_cnt, last_col: gen_last_col};

  lgs_rule_unit u_rule (
    .win       (win),
    .ctl       (ctl),
    .cell_next (cell_next)
  );

  always_comb begin
    up_addr = (row_cnt == '0) ? gen_last_row : lgs_pkg::ROW_W'(row_cnt - 1'b1);
    dn_addr = (row_cnt == gen_last_row) ? '0 : lgs_pkg::ROW_W'(row_cnt + 1'b1);
    case (state)
      ST_IDLE: rd_addr = req.row;
      ST_GUP:  rd_addr = up_addr;
      ST_GDN:  rd_addr = dn_addr;
      default: rd_addr = row_cnt;
    endcase
  end

  always_comb begin
    cell_wr_en   = 1'b0;
    cell_wr_addr = row_cnt;
    cell_wr_data = nx_rd_data;
    case (state)
      ST_CELL: begin
        cell_wr_en   = (item.action == lgs_pkg::ACT_WRITE);
        cell_wr_addr = item.row;
        cell_wr_data = row_data;
        cell_wr_data[item.col] = item.cell_value;
      end
      ST_CWR: begin
        cell_wr_en = 1'b1;
      end
      default: begin
        cell_wr_en = 1'b0;
      end
    endcase
  end

  // grid rows, read data registered
  always_ff @(posedge clk) begin
    if (cell_wr_en) begin
      cell_mem[cell_wr_addr] <= cell_wr_data;
    end
    rd_data <= cell_mem[rd_addr];
  end

  // scratch rows for the generation in progress
  always_ff @(posedge clk) begin
    if (state == ST_GWR) begin
      next_mem[row_cnt] <= next_row;
    end
    nx_rd_data <= next_mem[row_cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rsp_valid   <= 1'b0;
      row_valid   <= '0;
      rd_ok       <= 1'b0;
      clip_edges  <= 1'b0;
      rows_in_use <= lgs_pkg::CFG_W'(lgs_pkg::MAX_ROWS);
      cols_in_use <= lgs_pkg::CFG_W'(lgs_pkg::MAX_COLS);
    end else begin
      rd_ok <= row_valid[rd_addr];

      if (cfg_write) begin
        case (cfg_index)
          lgs_pkg::REG_CLIP: clip_edges  <= cfg_data[0];
          lgs_pkg::REG_ROWS: rows_in_use <= cfg_data;
          lgs_pkg::REG_COLS: cols_in_use <= cfg_data;
          default: ;
        endcase
      end

      if (rsp_valid && !rsp_stall && (state != ST_RESP)) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            item      <= req;
            res_alive <= 1'b0;
            case (req.action)
              lgs_pkg::ACT_STEP: begin
                res_status   <= 1'b0;
                row_cnt      <= '0;
                gen_last_row <= last_row;
                gen_last_col <= last_col;
                state        <= ST_GUP;
              end
              lgs_pkg::ACT_WRITE, lgs_pkg::ACT_READ: begin
                if ((req.row > last_row) || (req.col > last_col)) begin
                  res_status <= 1'b1;
                  state      <= ST_RESP;
                end else begin
                  res_status <= 1'b0;
                  state      <= ST_CELL;
                end
              end
              default: begin
                res_status <= 1'b0;
                state      <= ST_RESP;
              end
            endcase
          end
        end
        ST_CELL: begin
          if (item.action == lgs_pkg::ACT_WRITE) begin
            row_valid[item.row] <= 1'b1;
          end else begin
            res_alive <= row_data[item.col];
          end
          state <= ST_RESP;
        end
        ST_GUP: begin
          state <= ST_GCUR;
        end
        ST_GCUR: begin
          up_row <= (clip_edges && (row_cnt == '0)) ? '0 : row_data;
          state  <= ST_GDN;
        end
        ST_GDN: begin
          cur_row <= row_data;
          state   <= ST_GLOAD;
        end
        ST_GLOAD: begin
          dn_row   <= (clip_edges && (row_cnt == gen_last_row)) ? '0 : row_data;
          next_row <= cur_row;
          col_cnt  <= '0;
          state    <= ST_GCOL;
        end
        ST_GCOL: begin
          next_row[col_cnt] <= cell_next;
          if (col_cnt == gen_last_col) begin
            state <= ST_GWR;
          end else begin
            col_cnt <= lgs_pkg::COL_W'(col_cnt + 1'b1);
          end
        end
        ST_GWR: begin
          if (row_cnt == gen_last_row) begin
            row_cnt <= '0;
            state   <= ST_CRD;
          end else begin
            row_cnt <= lgs_pkg::ROW_W'(row_cnt + 1'b1);
            state   <= ST_GUP;
          end
        end
        ST_CRD: begin
          state <= ST_CWR;
        end
        ST_CWR: begin
          row_valid[row_cnt] <= 1'b1;
          if (row_cnt == gen_last_row) begin
            state <= ST_RESP;
          end else begin
            row_cnt <= lgs_pkg::ROW_W'(row_cnt + 1'b1);
            state   <= ST_CRD;
          end
        end
        ST_RESP: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp       <= '{alive: res_alive, status: res_status};
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GCOL) |-> (col_cnt <= gen_last_col))
    else $error("column counter beyond active width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_GUP) || (state == ST_GCOL) || (state == ST_GWR) ||
     (state == ST_CRD) || (state == ST_CWR)) |-> (row_cnt <= gen_last_row))
    else $error("row counter beyond active height");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> ((row_valid == '0) && !rsp_valid))
    else $error("grid or response not cleared by reset");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_RESP))
    else $error("response beat raised outside response state");
`endif

endmodule

// ----- hw/rtl/lgs_rule_unit.sv -----
// ----------------------------------------------------------------------------
// lgs_rule_unit
// Neighbor count and B3/S23 rule for one cell of a three-row window.
// ----------------------------------------------------------------------------
module lgs_rule_unit (
  input  lgs_pkg::window_t  win,
  input  lgs_pkg::col_ctl_t ctl,
  output logic              cell_next
);

  logic [lgs_pkg::COL_W-1:0] li;
  logic [lgs_pkg::COL_W-1:0] ri;
  logic                      lok;
  logic                      rok;
  logic [7:0]                nb;
  logic [lgs_pkg::CNT_W-1:0] count;

  always_comb begin
    li  = (ctl.col == '0) ? ctl.last_col : lgs_pkg::COL_W'(ctl.col - 1'b1);
    ri  = (ctl.col == ctl.last_col) ? '0 : lgs_pkg::COL_W'(ctl.col + 1'b1);
    lok = !(ctl.clip && (ctl.col == '0));
    rok = !(ctl.clip && (ctl.col == ctl.last_col));

    nb[0] = win.up[li] & lok;
    nb[1] = win.up[ctl.col];
    nb[2] = win.up[ri] & rok;
    nb[3] = win.cur[li] & lok;
    nb[4] = win.cur[ri] & rok;
    nb[5] = win.dn[li] & lok;
    nb[6] = win.dn[ctl.col];
    nb[7] = win.dn[ri] & rok;

    count = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + {{(lgs_pkg::CNT_W-1){1'b0}}, nb[i]};
    end

    cell_next = (count == lgs_pkg::BIRTH_COUNT) ||
                ((count == lgs_pkg::SURVIVE_COUNT) && win.cur[ctl.col]);
  end

endmodule

// ----- dv/tb_life_generation_step.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_life_generation_step
// Self-checking testbench for the life generation step block. Cell writes,
// reads and generation steps go in over the request channel; each response is
// compared with a cycle-free grid predictor. Region size and edge mode are
// rewritten between phases; the request channel idles and the response channel stalls at random.
// ----------------------------------------------------------------------------
module tb_life_generation_step;

  localparam logic [1:0] ACT_UNUSED    = 2'd3;
  localparam int         HOLD_CYCLES   = 150;
  localparam int         IDLE_LIMIT    = 20000;
  localparam int         REPORT_LIMIT  = 10;

  typedef struct {
    lgs_pkg::rsp_t want;
    lgs_pkg::req_t cmd;
    int unsigned   seq;
  } expected_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          req_valid = 1'b0;
  logic                          req_stall;
  lgs_pkg::req_t                 req = '0;
  logic                          rsp_valid;
  logic                          rsp_stall = 1'b0;
  lgs_pkg::rsp_t                 rsp;
  logic                          cfg_write = 1'b0;
  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lgs_pkg::CFG_W-1:0]     cfg_data = '0;

  // grid predictor state
  bit                        grid_now  [lgs_pkg::MAX_ROWS][lgs_pkg::MAX_COLS];
  bit                        grid_next [lgs_pkg::MAX_ROWS][lgs_pkg::MAX_COLS];
  bit                        clip_mode = 1'b0;
  logic [lgs_pkg::CFG_W-1:0] rows_reg  = lgs_pkg::CFG_W'(64);
  logic [lgs_pkg::CFG_W-1:0] cols_reg  = lgs_pkg::CFG_W'(64);

  expected_t   expected_rsp[$];
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned step_count = 0;
  int unsigned region_count = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_token = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned seg_left = 0;
  int unsigned seg_mode = 0;

  life_generation_step uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int region_size(logic [lgs_pkg::CFG_W-1:0] v, int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic int live_around(int r, int c, int nr, int nc);
    int n;
    int x;
    int y;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr == 0 && dc == 0) continue;
        x = r + dr;
        y = c + dc;
        if (clip_mode) begin
          if (x < 0 || y < 0 || x >= nr || y >= nc) continue;
        end else begin
          x = (x + nr) % nr;
          y = (y + nc) % nc;
        end
        n += grid_now[x][y];
      end
    end
    return n;
  endfunction

  function automatic void step_generation();
    int nr;
    int nc;
    int n;
    nr = region_size(rows_reg, lgs_pkg::MAX_ROWS);
    nc = region_size(cols_reg, lgs_pkg::MAX_COLS);
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        n = live_around(r, c, nr, nc);
        grid_next[r][c] = (n == 3) || (n == 2 && grid_now[r][c]);
      end
    end
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        grid_now[r][c] = grid_next[r][c];
      end
    end
  endfunction

  function automatic lgs_pkg::rsp_t predict_cell_op(lgs_pkg::req_t op);
    lgs_pkg::rsp_t res;
    int            nr;
    int            nc;
    res = '0;
    nr = region_size(rows_reg, lgs_pkg::MAX_ROWS);
    nc = region_size(cols_reg, lgs_pkg::MAX_COLS);
    if (op.action == lgs_pkg::ACT_STEP) begin
      step_generation();
    end else if (op.action == lgs_pkg::ACT_WRITE || op.action == lgs_pkg::ACT_READ) begin
      if (int'(op.row) >= nr || int'(op.col) >= nc) begin
        res.status = 1'b1;
      end else if (op.action == lgs_pkg::ACT_WRITE) begin
        grid_now[op.row][op.col] = op.cell_value;
      end else begin
        res.alive = grid_now[op.row][op.col];
      end
    end
    return res;
  endfunction

  function automatic lgs_pkg::req_t make_op(logic [1:0] a, logic [lgs_pkg::ROW_W-1:0] r,
                                            logic [lgs_pkg::COL_W-1:0] c, logic v);
    lgs_pkg::req_t op;
    op.action     = a;
    op.row        = r;
    op.col        = c;
    op.cell_value = v;
    return op;
  endfunction

  task automatic send_op(input lgs_pkg::req_t op);
    expected_t e;
    int unsigned gap;
    req_valid <= 1'b1;
    req <= op;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    e.want = predict_cell_op(op);
    e.cmd  = op;
    e.seq  = sent_count;
    expected_rsp.push_back(e);
    sent_count++;
    if (op.action == lgs_pkg::ACT_STEP) step_count++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 4);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_region(input bit clip, input logic [lgs_pkg::CFG_W-1:0] rows,
                              input logic [lgs_pkg::CFG_W-1:0] cols);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= lgs_pkg::REG_CLIP;
    cfg_data  <= {6'($urandom), clip};
    @(posedge clk);
    clip_mode = clip;
    cfg_index <= lgs_pkg::REG_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    rows_reg = rows;
    cfg_index <= lgs_pkg::REG_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    cols_reg = cols;
    cfg_write <= 1'b0;
    region_count++;
  endtask

  // response checker
  always @(posedge clk) begin
    expected_t e;
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      checked_count++;
      if (expected_rsp.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected response alive=%0b status=%0b", rsp.alive, rsp.status);
      end else begin
        e = expected_rsp.pop_front();
        if (rsp.alive !== e.want.alive || rsp.status !== e.want.status) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("op %0d (action %0d row %0d col %0d): %s alive=%0b status=%0b, %s",
                     e.seq, e.cmd.action, e.cmd.row, e.cmd.col, "expected",
                     e.want.alive, e.want.status, "got");
          if (mismatch_count <= REPORT_LIMIT)
            $display("  got alive=%0b status=%0b", rsp.alive, rsp.status);
        end
      end
    end
  end

  // response stall pattern, with a long hold on request
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(4, 40);
        seg_mode = $urandom_range(0, 2);
      end else begin
        seg_left--;
      end
      case (seg_mode)
        0: begin
          rsp_stall <= 1'b0;
        end
        1: begin
          rsp_stall <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          rsp_stall <= ($urandom_range(0, 9) < 7);
        end
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic test_reset_state();
    send_op(make_op(lgs_pkg::ACT_READ, 6'd0, 6'd0, 1'b1));
    send_op(make_op(lgs_pkg::ACT_READ, 6'd63, 6'd63, 1'b0));
    send_op(make_op(ACT_UNUSED, 6'd63, 6'd63, 1'b1));
  endtask

  task automatic test_corner_cells();
    send_op(make_op(lgs_pkg::ACT_WRITE, 6'd0, 6'd0, 1'b1));
    send_op(make_op(lgs_pkg::ACT_WRITE, 6'd63, 6'd63, 1'b1));
    send_op(make_op(lgs_pkg::ACT_WRITE, 6'd0, 6'd63, 1'b1));
    send_op(make_op(lgs_pkg::ACT_READ, 6'd0, 6'd63, 1'b0));
    send_op(make_op(lgs_pkg::ACT_READ, 6'd63, 6'd63, 1'b0));
    send_op(make_op(lgs_pkg::ACT_WRITE, 6'd63, 6'd63, 1'b0));
    send_op(make_op(lgs_pkg::ACT_READ, 6'd63, 6'd63, 1'b1));
  endtask

  task automatic test_full_grid_step();
    send_op(make_op(lgs_pkg::ACT_STEP, 6'd63, 6'd63, 1'b1));
    send_op(make_op(lgs_pkg::ACT_READ, 6'd0, 6'd0, 1'b0));
  endtask

  task automatic test_region_limits();
    write_region(1'b1, 7'd0, 7'd127);
    send_op(make_op(lgs_pkg::ACT_WRITE, 6'd1, 6'd5, 1'b1));
    send_op(make_op(lgs_pkg::ACT_READ, 6'd0, 6'd63, 1'b0));
    send_op(make_op(lgs_pkg::ACT_READ, 6'd63, 6'd0, 1'b0));
    write_region(1'b0, 7'd65, 7'd1);
    send_op(make_op(lgs_pkg::ACT_READ, 6'd63, 6'd0, 1'b0));
    send_op(make_op(lgs_pkg::ACT_READ, 6'd0, 6'd1, 1'b0));
  endtask

  task automatic test_tiny_wrap();
    write_region(1'b0, 7'd1, 7'd1);
    send_op(make_op(lgs_pkg::ACT_WRITE, 6'd0, 6'd0, 1'b1));
    send_op(make_op(lgs_pkg::ACT_STEP, 6'd0, 6'd0, 1'b0));
    send_op(make_op(lgs_pkg::ACT_READ, 6'd0, 6'd0, 1'b0));
  endtask

  task automatic test_clip_blinker();
    write_region(1'b1, 7'd3, 7'd3);
    send_op(make_op(lgs_pkg::ACT_WRITE, 6'd1, 6'd0, 1'b1));
    send_op(make_op(lgs_pkg::ACT_WRITE, 6'd1, 6'd1, 1'b1));
    send_op(make_op(lgs_pkg::ACT_WRITE, 6'd1, 6'd2, 1'b1));
    send_op(make_op(lgs_pkg::ACT_STEP, 6'd0, 6'd0, 1'b0));
    send_op(make_op(lgs_pkg::ACT_READ, 6'd0, 6'd1, 1'b0));
  endtask

  task automatic test_response_hold();
    write_region(1'b0, 7'd6, 7'd6);
    hold_token++;
    repeat (10) begin
      send_op(make_op($urandom_range(0, 1) ? lgs_pkg::ACT_WRITE : lgs_pkg::ACT_READ,
                      6'($urandom_range(0, 5)), 6'($urandom_range(0, 5)), 1'($urandom)));
    end
    wait_idle();
  endtask

  task automatic test_random_boards();
    int nr;
    int nc;
    int pick;
    int steps_left;
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 3) begin
        write_region(1'($urandom),
                     $urandom_range(0, 1) ? 7'd64 : 7'($urandom_range(65, 127)), 7'd127);
        steps_left = 2;
      end else begin
        write_region(1'(phase % 2), 7'($urandom_range(0, 9)), 7'($urandom_range(0, 9)));
        steps_left = 6;
      end
      nr = region_size(rows_reg, lgs_pkg::MAX_ROWS);
      nc = region_size(cols_reg, lgs_pkg::MAX_COLS);
      repeat (6) begin
        send_op(make_op(lgs_pkg::ACT_WRITE, 6'($urandom_range(0, nr - 1)),
                        6'($urandom_range(0, nc - 1)), $urandom_range(0, 3) != 0));
      end
      repeat (14) begin
        pick = $urandom_range(0, 99);
        if (pick < 20 && steps_left > 0) begin
          send_op(make_op(lgs_pkg::ACT_STEP, 6'($urandom), 6'($urandom), 1'($urandom)));
          steps_left--;
        end else if (pick < 40) begin
          send_op(make_op(lgs_pkg::ACT_WRITE, 6'($urandom_range(0, nr - 1)),
                          6'($urandom_range(0, nc - 1)), 1'($urandom)));
        end else if (pick < 85) begin
          send_op(make_op(lgs_pkg::ACT_READ, 6'($urandom_range(0, nr - 1)),
                          6'($urandom_range(0, nc - 1)), 1'($urandom)));
        end else if (pick < 95) begin
          send_op(make_op($urandom_range(0, 1) ? lgs_pkg::ACT_WRITE : lgs_pkg::ACT_READ,
                          6'($urandom), 6'($urandom), 1'($urandom)));
        end else begin
          send_op(make_op(ACT_UNUSED, 6'($urandom), 6'($urandom), 1'($urandom)));
        end
      end
    end
  endtask

  task automatic finish_run();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("covered %0d ops (%0d generation steps) over %0d region settings,",
             sent_count, step_count, region_count);
    $display("%0d responses checked, %0d mismatches", checked_count, mismatch_count);
    if (mismatch_count == 0 && expected_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_corner_cells();
    test_full_grid_step();
    test_region_limits();
    test_tiny_wrap();
    test_clip_blinker();
    test_response_hold();
    test_random_boards();
    finish_run();
  end

endmodule
